FILE: hdl/mta_pkg.sv
// shared types, constants and helpers for the station byte accounting table
// no dependencies
package mta_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W      = 48;
  localparam int LEN_W       = 16;
  localparam int RIDX_W      = 8;
  localparam int ECNT_W      = 9;
  localparam int CMP_W       = RIDX_W + CNT_W;

  localparam logic [ADDR_W-1:0] BCAST_ADDR = '1;
  localparam logic [ADDR_W-1:0] COUNT_MAX  = '1;

  typedef enum logic [1:0] {
    OP_READ,
    OP_IGNORE,
    OP_COUNT,
    OP_SELF
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] tx;
    logic [ADDR_W-1:0] rx;
    logic [LEN_W-1:0]  len;
    logic [RIDX_W-1:0] idx;
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_CNT_RD,
    S_TX_WR,
    S_RX_WR
  } bstate_t;

  function automatic logic [ADDR_W-1:0] sat_add(input logic [ADDR_W-1:0] cnt,
                                                input logic [LEN_W-1:0]  len);
    logic [ADDR_W:0] sum;
    sum = {1'b0, cnt} + {{(ADDR_W + 1 - LEN_W){1'b0}}, len};
    return sum[ADDR_W] ? COUNT_MAX : sum[ADDR_W-1:0];
  endfunction

endpackage

FILE: hdl/mta_front.sv
// front end: takes request items and classifies them into jobs
// depends on mta_pkg
module mta_front (
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cmd,
  input  logic [47:0]                 in_transmitter_addr,
  input  logic [47:0]                 in_recipient_addr,
  input  logic [15:0]                 in_frame_bytes,
  input  logic [7:0]                  in_read_index,
  input  logic                        q_full,
  output logic                        push,
  output mta_pkg::job_t               push_job
);
  import mta_pkg::*;

  always_comb begin
    in_stall     = q_full;
    push         = in_valid && !q_full;
    push_job.tx  = in_transmitter_addr;
    push_job.rx  = in_recipient_addr;
    push_job.len = in_frame_bytes;
    push_job.idx = in_read_index;
    if (in_cmd) begin
      push_job.op = OP_READ;
    end else if (in_recipient_addr == BCAST_ADDR) begin
      push_job.op = OP_IGNORE;
    end else if (in_transmitter_addr == in_recipient_addr) begin
      push_job.op = OP_SELF;
    end else begin
      push_job.op = OP_COUNT;
    end
  end

endmodule

FILE: hdl/mta_queue.sv
// two-entry job queue between front end and table engine
// depends on mta_pkg
module mta_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mta_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output mta_pkg::job_t head_job,
  output logic          empty
);
  import mta_pkg::*;

  job_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  assign full     = (fill_r == 2'd2);
  assign empty    = (fill_r == 2'd0);
  assign head_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
    else $error("queue pop while empty");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n) fill_r != 2'd3)
    else $error("queue fill out of range");

endmodule

FILE: hdl/mta_back.sv
// table engine: address scan, counter update, entry append and result register
// depends on mta_pkg
module mta_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  mta_pkg::job_t head_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [47:0]   out_entry_addr,
  output logic [47:0]   out_bytes_sent,
  output logic [47:0]   out_bytes_received,
  output logic          out_entry_valid,
  output logic [8:0]    out_entry_count,
  output logic          out_frame_ignored,
  output logic          out_table_full_drop
);
  import mta_pkg::*;

  logic [ADDR_W-1:0] addr_mem [TABLE_DEPTH];
  logic [ADDR_W-1:0] sent_mem [TABLE_DEPTH];
  logic [ADDR_W-1:0] recv_mem [TABLE_DEPTH];

  logic [ADDR_W-1:0] addr_q, sent_q, recv_q;
  logic [IDX_W-1:0]  a_raddr, s_raddr, r_raddr;
  logic              a_we, s_we, r_we;
  logic [IDX_W-1:0]  a_waddr, s_waddr, r_waddr;
  logic [ADDR_W-1:0] a_wdata, s_wdata, r_wdata;

  bstate_t           state_r, state_nxt;
  job_t              job_r, job_nxt;
  logic [IDX_W-1:0]  scan_r, scan_nxt;
  logic              tx_found_r, tx_found_nxt;
  logic              rx_found_r, rx_found_nxt;
  logic [IDX_W-1:0]  tx_idx_r, tx_idx_nxt;
  logic [IDX_W-1:0]  rx_idx_r, rx_idx_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              drop_r, drop_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [ADDR_W-1:0] out_sent_r, out_sent_nxt;
  logic [ADDR_W-1:0] out_recv_r, out_recv_nxt;
  logic              out_evld_r, out_evld_nxt;
  logic [ECNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic              out_ign_r, out_ign_nxt;
  logic              out_drop_r, out_drop_nxt;

  logic              start;
  logic              tx_hit, rx_hit, last_scan, has_room, rd_ok;

  assign start     = !q_empty && !out_valid_r;
  assign tx_hit    = tx_found_r || (addr_q == job_r.tx);
  assign rx_hit    = rx_found_r || (addr_q == job_r.rx);
  assign last_scan = ((CNT_W'(scan_r) + CNT_W'(1)) == count_r);
  assign has_room  = (count_r < CNT_W'(TABLE_DEPTH));
  assign rd_ok     = (CMP_W'(job_r.idx) < CMP_W'(count_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (head_job.op)
            OP_READ:   state_nxt = S_READ;
            OP_IGNORE: state_nxt = S_IDLE;
            default:   state_nxt = (count_r == '0) ? S_CNT_RD : S_SCAN_RD;
          endcase
        end
      end
      S_READ:     state_nxt = S_IDLE;
      S_SCAN_RD:  state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: state_nxt = (last_scan || (tx_hit && rx_hit)) ? S_CNT_RD : S_SCAN_RD;
      S_CNT_RD:   state_nxt = S_TX_WR;
      S_TX_WR:    state_nxt = (job_r.op == OP_COUNT) ? S_RX_WR : S_IDLE;
      S_RX_WR:    state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    pop           = 1'b0;
    job_nxt       = job_r;
    scan_nxt      = scan_r;
    tx_found_nxt  = tx_found_r;
    rx_found_nxt  = rx_found_r;
    tx_idx_nxt    = tx_idx_r;
    rx_idx_nxt    = rx_idx_r;
    count_nxt     = count_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_addr_nxt  = out_addr_r;
    out_sent_nxt  = out_sent_r;
    out_recv_nxt  = out_recv_r;
    out_evld_nxt  = out_evld_r;
    out_cnt_nxt   = out_cnt_r;
    out_ign_nxt   = out_ign_r;
    out_drop_nxt  = out_drop_r;
    a_raddr       = scan_r;
    s_raddr       = tx_idx_r;
    r_raddr       = rx_idx_r;
    a_we          = 1'b0;
    s_we          = 1'b0;
    r_we          = 1'b0;
    a_waddr       = IDX_W'(count_r);
    s_waddr       = tx_idx_r;
    r_waddr       = rx_idx_r;
    a_wdata       = job_r.tx;
    s_wdata       = '0;
    r_wdata       = '0;
    case (state_r)
      S_IDLE: begin
        a_raddr = IDX_W'(head_job.idx);
        s_raddr = IDX_W'(head_job.idx);
        r_raddr = IDX_W'(head_job.idx);
        if (start) begin
          pop          = 1'b1;
          job_nxt      = head_job;
          scan_nxt     = '0;
          tx_found_nxt = 1'b0;
          rx_found_nxt = 1'b0;
          drop_nxt     = 1'b0;
          if (head_job.op == OP_IGNORE) begin
            out_valid_nxt = 1'b1;
            out_addr_nxt  = '0;
            out_sent_nxt  = '0;
            out_recv_nxt  = '0;
            out_evld_nxt  = 1'b0;
            out_cnt_nxt   = ECNT_W'(count_r);
            out_ign_nxt   = 1'b1;
            out_drop_nxt  = 1'b0;
          end
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        out_addr_nxt  = rd_ok ? addr_q : '0;
        out_sent_nxt  = rd_ok ? sent_q : '0;
        out_recv_nxt  = rd_ok ? recv_q : '0;
        out_evld_nxt  = rd_ok;
        out_cnt_nxt   = ECNT_W'(count_r);
        out_ign_nxt   = 1'b0;
        out_drop_nxt  = 1'b0;
      end
      S_SCAN_CMP: begin
        if (!tx_found_r && addr_q == job_r.tx) begin
          tx_found_nxt = 1'b1;
          tx_idx_nxt   = scan_r;
        end
        if (!rx_found_r && addr_q == job_r.rx) begin
          rx_found_nxt = 1'b1;
          rx_idx_nxt   = scan_r;
        end
        scan_nxt = scan_r + IDX_W'(1);
      end
      S_TX_WR: begin
        if (tx_found_r) begin
          s_we    = 1'b1;
          s_waddr = tx_idx_r;
          s_wdata = sat_add(sent_q, job_r.len);
          if (job_r.op == OP_SELF) begin
            r_we    = 1'b1;
            r_waddr = tx_idx_r;
            r_wdata = sat_add(recv_q, job_r.len);
          end
        end else if (has_room) begin
          a_we      = 1'b1;
          a_waddr   = IDX_W'(count_r);
          a_wdata   = job_r.tx;
          s_we      = 1'b1;
          s_waddr   = IDX_W'(count_r);
          s_wdata   = {{(ADDR_W - LEN_W){1'b0}}, job_r.len};
          r_we      = 1'b1;
          r_waddr   = IDX_W'(count_r);
          r_wdata   = (job_r.op == OP_SELF) ? {{(ADDR_W - LEN_W){1'b0}}, job_r.len} : '0;
          count_nxt = count_r + CNT_W'(1);
        end else begin
          drop_nxt = 1'b1;
        end
        if (job_r.op == OP_SELF) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = '0;
          out_sent_nxt  = '0;
          out_recv_nxt  = '0;
          out_evld_nxt  = 1'b0;
          out_cnt_nxt   = ECNT_W'(count_nxt);
          out_ign_nxt   = 1'b0;
          out_drop_nxt  = drop_nxt;
        end
      end
      S_RX_WR: begin
        if (rx_found_r) begin
          r_we    = 1'b1;
          r_waddr = rx_idx_r;
          r_wdata = sat_add(recv_q, job_r.len);
        end else if (has_room) begin
          a_we      = 1'b1;
          a_waddr   = IDX_W'(count_r);
          a_wdata   = job_r.rx;
          s_we      = 1'b1;
          s_waddr   = IDX_W'(count_r);
          s_wdata   = '0;
          r_we      = 1'b1;
          r_waddr   = IDX_W'(count_r);
          r_wdata   = {{(ADDR_W - LEN_W){1'b0}}, job_r.len};
          count_nxt = count_r + CNT_W'(1);
        end else begin
          drop_nxt = 1'b1;
        end
        out_valid_nxt = 1'b1;
        out_addr_nxt  = '0;
        out_sent_nxt  = '0;
        out_recv_nxt  = '0;
        out_evld_nxt  = 1'b0;
        out_cnt_nxt   = ECNT_W'(count_nxt);
        out_ign_nxt   = 1'b0;
        out_drop_nxt  = drop_nxt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    scan_r     <= scan_nxt;
    tx_found_r <= tx_found_nxt;
    rx_found_r <= rx_found_nxt;
    tx_idx_r   <= tx_idx_nxt;
    rx_idx_r   <= rx_idx_nxt;
    drop_r     <= drop_nxt;
    out_addr_r <= out_addr_nxt;
    out_sent_r <= out_sent_nxt;
    out_recv_r <= out_recv_nxt;
    out_evld_r <= out_evld_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_ign_r  <= out_ign_nxt;
    out_drop_r <= out_drop_nxt;
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      addr_mem[a_waddr] <= a_wdata;
    end
    addr_q <= addr_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      sent_mem[s_waddr] <= s_wdata;
    end
    sent_q <= sent_mem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (r_we) begin
      recv_mem[r_waddr] <= r_wdata;
    end
    recv_q <= recv_mem[r_raddr];
  end

  assign out_valid           = out_valid_r;
  assign out_entry_addr      = out_addr_r;
  assign out_bytes_sent      = out_sent_r;
  assign out_bytes_received  = out_recv_r;
  assign out_entry_valid     = out_evld_r;
  assign out_entry_count     = out_cnt_r;
  assign out_frame_ignored   = out_ign_r;
  assign out_table_full_drop = out_drop_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
      count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
      state_r != S_TX_WR && state_r != S_RX_WR |=> $stable(count_r))
    else $error("entry count moved outside an update");
  a_pop_free: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !out_valid_r)
    else $error("job taken while result still pending");
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
      state_r == S_SCAN_CMP |-> CNT_W'(scan_r) < count_r)
    else $error("scan past stored entries");

endmodule

FILE: hdl/mac_traffic_accounting_table.sv
// Station byte accounting table. Each request is accepted into a two-entry queue,
// so the input keeps taking requests while a result waits on out_stall, until the
// queue is full. The table engine works on one job at a time and takes the next
// only after its result has been handed over. A count request scans the stored
// addresses one entry at a time through the single read port of the address
// memory, stopping once both stations are found or the last stored entry is
// compared. It then does the counter read-modify-write and any appends in the
// states S_CNT_RD, S_TX_WR and, for two distinct stations, S_RX_WR. A waiting
// result holds the engine for as long as out_stall is high. Table storage needs
// no clearing after reset; only the entry count is reset.
module mac_traffic_accounting_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [47:0] in_transmitter_addr,
  input  logic [47:0] in_recipient_addr,
  input  logic [15:0] in_frame_bytes,
  input  logic [7:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] out_entry_addr,
  output logic [47:0] out_bytes_sent,
  output logic [47:0] out_bytes_received,
  output logic        out_entry_valid,
  output logic [8:0]  out_entry_count,
  output logic        out_frame_ignored,
  output logic        out_table_full_drop
);
  import mta_pkg::*;

  logic q_full, q_empty, push, pop;
  job_t push_job, head_job;

  mta_front u_front (
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_transmitter_addr (in_transmitter_addr),
    .in_recipient_addr   (in_recipient_addr),
    .in_frame_bytes      (in_frame_bytes),
    .in_read_index       (in_read_index),
    .q_full              (q_full),
    .push                (push),
    .push_job            (push_job)
  );

  mta_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty)
  );

  mta_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .head_job            (head_job),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_entry_addr      (out_entry_addr),
    .out_bytes_sent      (out_bytes_sent),
    .out_bytes_received  (out_bytes_received),
    .out_entry_valid     (out_entry_valid),
    .out_entry_count     (out_entry_count),
    .out_frame_ignored   (out_frame_ignored),
    .out_table_full_drop (out_table_full_drop)
  );

endmodule

FILE: sim/mta_table_checker.sv
// checker for the station byte accounting table: watches both channels,
// keeps its own copy of the table and compares every result; uses mta_pkg
`timescale 1ns / 1ps
module mta_table_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      in_cmd,
  input  logic [mta_pkg::ADDR_W-1:0] in_transmitter_addr,
  input  logic [mta_pkg::ADDR_W-1:0] in_recipient_addr,
  input  logic [mta_pkg::LEN_W-1:0]  in_frame_bytes,
  input  logic [mta_pkg::RIDX_W-1:0] in_read_index,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [mta_pkg::ADDR_W-1:0] out_entry_addr,
  input  logic [mta_pkg::ADDR_W-1:0] out_bytes_sent,
  input  logic [mta_pkg::ADDR_W-1:0] out_bytes_received,
  input  logic                      out_entry_valid,
  input  logic [mta_pkg::ECNT_W-1:0] out_entry_count,
  input  logic                      out_frame_ignored,
  input  logic                      out_table_full_drop,
  output int                        fail_count,
  output int                        pending
);
  import mta_pkg::*;

  typedef struct {
    logic [ADDR_W-1:0] entry_addr;
    logic [ADDR_W-1:0] sent;
    logic [ADDR_W-1:0] received;
    logic              entry_valid;
    logic [ECNT_W-1:0] entry_count;
    logic              ignored;
    logic              full_drop;
  } acct_result_t;

  logic [ADDR_W-1:0] stn_addr [TABLE_DEPTH];
  logic [ADDR_W-1:0] stn_sent [TABLE_DEPTH];
  logic [ADDR_W-1:0] stn_recv [TABLE_DEPTH];
  int                n_stations;
  acct_result_t      expected_results [$];

  function automatic logic [ADDR_W-1:0] add_sat(logic [ADDR_W-1:0] c, logic [LEN_W-1:0] n);
    logic [ADDR_W:0] s;
    s = {1'b0, c} + (ADDR_W + 1)'(n);
    return s[ADDR_W] ? '1 : s[ADDR_W-1:0];
  endfunction

  function automatic int lookup(logic [ADDR_W-1:0] a);
    for (int i = 0; i < n_stations; i++)
      if (stn_addr[i] == a) return i;
    return -1;
  endfunction

  function automatic bit append(logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] s,
                                logic [ADDR_W-1:0] r);
    if (n_stations >= TABLE_DEPTH) return 0;
    stn_addr[n_stations] = a;
    stn_sent[n_stations] = s;
    stn_recv[n_stations] = r;
    n_stations++;
    return 1;
  endfunction

  function automatic acct_result_t account(logic cmd, logic [ADDR_W-1:0] tx,
                                           logic [ADDR_W-1:0] rx, logic [LEN_W-1:0] len,
                                           logic [RIDX_W-1:0] idx);
    acct_result_t r;
    int k;
    r = '{default: '0};
    if (cmd) begin
      if (idx < n_stations) begin
        r.entry_addr  = stn_addr[idx];
        r.sent        = stn_sent[idx];
        r.received    = stn_recv[idx];
        r.entry_valid = 1'b1;
      end
    end else if (rx == BCAST_ADDR) begin
      r.ignored = 1'b1;
    end else begin
      k = lookup(tx);
      if (k >= 0) begin
        stn_sent[k] = add_sat(stn_sent[k], len);
        if (tx == rx) stn_recv[k] = add_sat(stn_recv[k], len);
      end else if (!append(tx, ADDR_W'(len), (tx == rx) ? ADDR_W'(len) : '0)) begin
        r.full_drop = 1'b1;
      end
      if (tx != rx) begin
        k = lookup(rx);
        if (k >= 0) stn_recv[k] = add_sat(stn_recv[k], len);
        else if (!append(rx, '0, ADDR_W'(len))) r.full_drop = 1'b1;
      end
    end
    r.entry_count = ECNT_W'(n_stations);
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    acct_result_t e;
    if (!rst_n) begin
      n_stations = 0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(account(in_cmd, in_transmitter_addr, in_recipient_addr,
                                           in_frame_bytes, in_read_index));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_entry_addr !== e.entry_addr) begin
            $error("entry_addr exp %h got %h", e.entry_addr, out_entry_addr); fail_count++;
          end
          if (out_bytes_sent !== e.sent) begin
            $error("bytes_sent exp %h got %h", e.sent, out_bytes_sent); fail_count++;
          end
          if (out_bytes_received !== e.received) begin
            $error("bytes_received exp %h got %h", e.received, out_bytes_received);
            fail_count++;
          end
          if (out_entry_valid !== e.entry_valid) begin
            $error("entry_valid exp %b got %b", e.entry_valid, out_entry_valid); fail_count++;
          end
          if (out_entry_count !== e.entry_count) begin
            $error("entry_count exp %0d got %0d", e.entry_count, out_entry_count);
            fail_count++;
          end
          if (out_frame_ignored !== e.ignored) begin
            $error("frame_ignored exp %b got %b", e.ignored, out_frame_ignored); fail_count++;
          end
          if (out_table_full_drop !== e.full_drop) begin
            $error("table_full_drop exp %b got %b", e.full_drop, out_table_full_drop);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

FILE: sim/mac_traffic_accounting_table_tb.sv
// testbench top for mac_traffic_accounting_table: drives requests under
// several idle and stall mixes; checking lives in mta_table_checker
`timescale 1ns / 1ps
module mac_traffic_accounting_table_tb;
  import mta_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_cmd;
  logic [ADDR_W-1:0] in_transmitter_addr;
  logic [ADDR_W-1:0] in_recipient_addr;
  logic [LEN_W-1:0]  in_frame_bytes;
  logic [RIDX_W-1:0] in_read_index;
  logic              out_valid;
  logic              out_stall;
  logic [ADDR_W-1:0] out_entry_addr;
  logic [ADDR_W-1:0] out_bytes_sent;
  logic [ADDR_W-1:0] out_bytes_received;
  logic              out_entry_valid;
  logic [ECNT_W-1:0] out_entry_count;
  logic              out_frame_ignored;
  logic              out_table_full_drop;
  int                fail_count;
  int                pending;

  int                send_idle_pct;
  int                stall_pct;
  bit                long_hold;
  logic [ADDR_W-1:0] station_pool [40];

  mac_traffic_accounting_table u_dut (.*);

  mta_table_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("== FAIL ==");
    $finish;
  end

  // receiver side, with one long hold-off to back up the input
  initial begin
    bit hold_done;
    hold_done = 0;
    out_stall = 1'b0;
    forever begin
      if (long_hold && !hold_done) begin
        for (int c = 0; c < 400; c++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
        hold_done = 1;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
      @(posedge clk);
    end
  end

  task automatic send_req(logic cmd, logic [ADDR_W-1:0] tx, logic [ADDR_W-1:0] rx,
                          logic [LEN_W-1:0] len, logic [RIDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_cmd              <= cmd;
    in_transmitter_addr <= tx;
    in_recipient_addr   <= rx;
    in_frame_bytes      <= len;
    in_read_index       <= idx;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pool_frame();
    int sel;
    logic [ADDR_W-1:0] tx, rx;
    sel = $urandom_range(99);
    tx  = station_pool[$urandom_range(39)];
    rx  = station_pool[$urandom_range(39)];
    if (sel < 15)
      send_req(1'b1, ADDR_W'({$urandom, $urandom}), ADDR_W'({$urandom, $urandom}),
               LEN_W'($urandom),
               ($urandom_range(3) == 0) ? RIDX_W'($urandom) : RIDX_W'($urandom_range(50)));
    else if (sel < 25) send_req(1'b0, tx, BCAST_ADDR, LEN_W'($urandom), RIDX_W'($urandom));
    else if (sel < 35) send_req(1'b0, tx, tx, LEN_W'($urandom), RIDX_W'($urandom));
    else if (sel < 38)
      send_req(1'b0, ADDR_W'({$urandom, $urandom}), rx, LEN_W'($urandom), RIDX_W'($urandom));
    else send_req(1'b0, tx, rx, LEN_W'($urandom), RIDX_W'($urandom));
  endtask

  initial begin
    logic [ADDR_W-1:0] a, b;
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_cmd              = 1'b0;
    in_transmitter_addr = '0;
    in_recipient_addr   = '0;
    in_frame_bytes      = '0;
    in_read_index       = '0;
    send_idle_pct       = 0;
    stall_pct           = 0;
    long_hold           = 0;
    station_pool[0] = '0;
    station_pool[1] = 48'hFFFF_FFFF_FFFE;
    station_pool[2] = 48'h8000_0000_0000;
    station_pool[3] = 48'h5555_5555_5555;
    station_pool[4] = 48'hAAAA_AAAA_AAAA;
    for (int i = 5; i < 40; i++) station_pool[i] = ADDR_W'({$urandom, $urandom});
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty reads, extremes, self traffic, broadcast, all-ones sender
    send_req(1'b1, '0, '0, '0, 8'd0);
    send_req(1'b1, '1, '1, '1, 8'hFF);
    send_req(1'b0, 48'h0, 48'hFFFF_FFFF_FFFE, 16'hFFFF, '0);
    send_req(1'b0, 48'h0, 48'hFFFF_FFFF_FFFE, 16'hFFFF, '0);
    send_req(1'b0, 48'hFFFF_FFFF_FFFE, 48'h0, 16'h0, '0);
    send_req(1'b0, 48'h1234_5678_9ABC, 48'h1234_5678_9ABC, 16'h0101, '0);
    send_req(1'b0, 48'h1234_5678_9ABC, 48'h1234_5678_9ABC, 16'h8000, '0);
    send_req(1'b0, 48'hDEAD_BEEF_0001, BCAST_ADDR, 16'h0042, '0);
    send_req(1'b0, BCAST_ADDR, 48'h0, 16'h0007, '0);
    send_req(1'b0, 48'h0, BCAST_ADDR, 16'hFFFF, '0);
    send_req(1'b0, 48'h0, 48'h1234_5678_9ABC, 16'h0001, '0);
    for (int i = 0; i < 6; i++) send_req(1'b1, '0, '0, '0, RIDX_W'(i));
    send_req(1'b1, '0, '0, '0, 8'd255);
    send_req(1'b1, '0, '0, '0, 8'd4);

    // random traffic over a small station set, four idle/stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 83 : (ph == 3) ? 19 : 0;
      stall_pct     = (ph == 2) ? 83 : (ph == 3) ? 19 : 0;
      if (ph == 0) long_hold = 1;
      for (int n = 0; n < 430; n++) pool_frame();
    end

    // fill the table with fresh pairs, then run against a full table
    send_idle_pct = 10;
    stall_pct     = 10;
    for (int i = 0; i < 120; i++) begin
      a = {16'hA5A5, 32'(2 * i)};
      send_req(1'b0, a, a + ADDR_W'(1), LEN_W'($urandom), '0);
    end
    for (int n = 0; n < 80; n++) begin
      a = ADDR_W'({$urandom, $urandom});
      b = station_pool[$urandom_range(39)];
      case ($urandom_range(4))
        0: send_req(1'b1, '0, '0, '0, RIDX_W'($urandom));
        1: send_req(1'b0, a, b, LEN_W'($urandom), '0);
        2: send_req(1'b0, b, a, LEN_W'($urandom), '0);
        3: send_req(1'b0, a, a, LEN_W'($urandom), '0);
        default: pool_frame();
      endcase
    end
    for (int i = 0; i < 256; i += 17) send_req(1'b1, '0, '0, '0, RIDX_W'(i));
    send_req(1'b1, '0, '0, '0, 8'd255);
    in_valid <= 1'b0;

    stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
